@@ rtl/rc_arming_and_mode_select_macros.svh @@
// Assertion macros shared by the arming and mode select logic.
`ifndef RC_ARMING_AND_MODE_SELECT_MACROS_SVH
`define RC_ARMING_AND_MODE_SELECT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCAMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCAMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rcams_pkg.sv @@
// Types and constants of the arming and flight mode select block.
package rcams_pkg;

	localparam int NUM_WIN = 6;
	localparam int CFG_IDX_W = 3;
	localparam int WIN_W = 29;

	localparam logic [WIN_W-1:0] WIN_RESET = 29'h07D07D0;

	localparam logic [3:0] THROTTLE_CH = 4'd2;
	localparam logic [3:0] SLOT_MAX = 4'd15;
	localparam logic [3:0] HOLD_MAX = 4'd15;
	localparam logic [10:0] THROTTLE_LIMIT = 11'd1020;
	localparam logic [23:0] SILENCE_LIMIT = 24'd500000;

	// Window register indexes, which are also the bit positions in the hit vectors.
	localparam logic [CFG_IDX_W-1:0] WIN_ARM = 3'd0;
	localparam logic [CFG_IDX_W-1:0] WIN_ANGLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] WIN_ALTHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] WIN_GPS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] WIN_WAYPOINT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] WIN_POWER = 3'd5;

	// Arming block flags.
	localparam logic [7:0] FLAG_HOLD = 8'h01;
	localparam logic [7:0] FLAG_THROTTLE = 8'h02;
	localparam logic [7:0] FLAG_NO_GPS = 8'h04;
	localparam logic [7:0] FLAG_CFG_A = 8'h08;
	localparam logic [7:0] FLAG_LINK = 8'h10;
	localparam logic [7:0] FLAG_MODE = 8'h20;
	localparam logic [7:0] FLAG_GYRO = 8'h40;
	localparam logic [7:0] FLAG_CFG_B = 8'h80;

	typedef enum logic [2:0] {
		MODE_ACRO,
		MODE_ANGLE,
		MODE_ALTHOLD,
		MODE_GPS,
		MODE_WAYPOINT
	} mode_t;

	typedef enum logic [1:0] {
		CAUSE_NONE,
		CAUSE_SWITCH,
		CAUSE_RX_LOSS
	} cause_t;

	typedef enum logic [2:0] {
		ALERT_NONE,
		ALERT_GYRO,
		ALERT_GPS,
		ALERT_CONFIG,
		ALERT_LINK,
		ALERT_MODE,
		ALERT_THROTTLE
	} alert_t;

	typedef struct packed {
		logic enable;
		logic [3:0] channel;
		logic [11:0] high;
		logic [11:0] low;
	} win_t;

	typedef struct packed {
		logic req_type;
		logic [10:0] channel_value;
		logic last_channel;
		logic link_up;
		logic [23:0] rx_silence_us;
		logic [3:0] other_blockers;
	} item_t;

	typedef struct packed {
		logic armed;
		logic [7:0] block_flags;
		mode_t flight_mode;
		logic mode_changed;
		logic arm_event;
		cause_t disarm_cause;
		alert_t refusal_alert;
		logic power_enable;
	} result_t;

endpackage

@@ rtl/rc_arming_and_mode_select.sv @@
// Arming and flight mode select driven by radio-control channel items.
//
//   channel  direction  handshake                  payload
//   item     in         item_valid/item_stall      rcams_pkg::item_t
//   result   out        result_valid/result_stall  rcams_pkg::result_t
//   cfg      in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One item is taken every cycle while item_stall is low; the input register and the result
// register bound a single stage of window comparators and arming logic, so an item is held
// in the input register and its result is offered from the result register. Channel items
// that are not the last of a packet give no result.
// Reset loads the window registers with their defaults and clears the valid flags and the arming and mode state.
// A stalled result holds the stage only for items that would give a result.
module rc_arming_and_mode_select #(
	parameter int NUM_CHANNELS = 16,
	parameter int ARM_HOLD_PACKETS = 10
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input rcams_pkg::item_t item,
	output logic result_valid,
	input logic result_stall,
	output rcams_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [rcams_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rcams_pkg::WIN_W-1:0] cfg_data
);
	import rcams_pkg::*;

	`include "rc_arming_and_mode_select_macros.svh"

	win_t win_q [NUM_WIN];

	logic s1_valid_s1;
	item_t item_s1;
	logic s1_go;
	logic s1_emits;

	logic result_valid_q;
	result_t result_q;

	logic armed_q;
	logic [3:0] hold_q;
	logic [7:0] flags_q;
	mode_t mode_q;
	logic [3:0] slot_q;
	logic [NUM_WIN-1:0] pend_q;
	logic [NUM_WIN-1:0] hits_q;
	logic thr_q;

	logic armed_n;
	logic [3:0] hold_n;
	logic [7:0] flags_n;
	mode_t mode_n;
	logic [3:0] slot_n;
	logic [NUM_WIN-1:0] pend_n;
	logic [NUM_WIN-1:0] hits_n;
	logic thr_n;
	result_t res;

	logic slot_ok;
	logic [NUM_WIN-1:0] win_hit;
	logic [NUM_WIN-1:0] win_sel;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WIN; i++) begin
				win_q[i] <= win_t'(WIN_RESET);
			end
		end else if (cfg_valid && cfg_ready && ({29'd0, cfg_index} < 32'(NUM_WIN))) begin
			win_q[cfg_index] <= win_t'(cfg_data);
		end
	end

	assign s1_emits = item_s1.req_type || item_s1.last_channel;
	assign s1_go = s1_valid_s1 && (!s1_emits || !result_valid_q || !result_stall);
	assign item_stall = s1_valid_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_go) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		slot_ok = {1'b0, slot_q} < 5'(NUM_CHANNELS);
		for (int i = 0; i < NUM_WIN; i++) begin
			win_hit[i] = win_q[i].enable
				&& ({1'b0, item_s1.channel_value} >= win_q[i].low)
				&& ({1'b0, item_s1.channel_value} <= win_q[i].high);
			win_sel[i] = slot_ok && (win_q[i].channel == slot_q);
		end
	end

	always_comb begin
		armed_n = armed_q;
		hold_n = hold_q;
		flags_n = flags_q;
		mode_n = mode_q;
		slot_n = slot_q;
		pend_n = pend_q;
		hits_n = hits_q;
		thr_n = thr_q;
		res.mode_changed = 1'b0;
		res.arm_event = 1'b0;
		res.disarm_cause = CAUSE_NONE;
		res.refusal_alert = ALERT_NONE;
		if (item_s1.req_type) begin
			if (armed_q && (item_s1.rx_silence_us >= SILENCE_LIMIT)) begin
				armed_n = 1'b0;
				res.disarm_cause = CAUSE_RX_LOSS;
			end
		end else begin
			for (int i = 0; i < NUM_WIN; i++) begin
				if (win_sel[i]) begin
					pend_n[i] = win_hit[i];
				end
			end
			if (slot_ok && (slot_q == THROTTLE_CH)) begin
				thr_n = item_s1.channel_value < THROTTLE_LIMIT;
			end
			if (!item_s1.last_channel) begin
				if (slot_q != SLOT_MAX) begin
					slot_n = slot_q + 4'd1;
				end
			end else begin
				slot_n = '0;
				hits_n = pend_n;
				if (hits_n[WIN_ARM]) begin
					hold_n = (hold_q == HOLD_MAX) ? hold_q : hold_q + 4'd1;
				end else begin
					hold_n = '0;
				end
				if (!armed_q) begin
					flags_n = '0;
					if (hold_n != 4'(ARM_HOLD_PACKETS)) flags_n |= FLAG_HOLD;
					if (!thr_n) flags_n |= FLAG_THROTTLE;
					if (item_s1.other_blockers[1]) flags_n |= FLAG_NO_GPS;
					if (item_s1.other_blockers[2]) flags_n |= FLAG_CFG_A;
					if (!item_s1.link_up) flags_n |= FLAG_LINK;
					if (mode_q > MODE_ANGLE) flags_n |= FLAG_MODE;
					if (item_s1.other_blockers[0]) flags_n |= FLAG_GYRO;
					if (item_s1.other_blockers[3]) flags_n |= FLAG_CFG_B;
					if (flags_n == '0) begin
						armed_n = 1'b1;
						res.arm_event = 1'b1;
					end else if ((hold_n == 4'(ARM_HOLD_PACKETS)) && item_s1.link_up) begin
						priority if ((flags_n & FLAG_GYRO) != '0) begin
							res.refusal_alert = ALERT_GYRO;
						end else if ((flags_n & FLAG_NO_GPS) != '0) begin
							res.refusal_alert = ALERT_GPS;
						end else if ((flags_n & (FLAG_CFG_A | FLAG_CFG_B)) != '0) begin
							res.refusal_alert = ALERT_CONFIG;
						end else if ((flags_n & FLAG_LINK) != '0) begin
							res.refusal_alert = ALERT_LINK;
						end else if ((flags_n & FLAG_MODE) != '0) begin
							res.refusal_alert = ALERT_MODE;
						end else if ((flags_n & FLAG_THROTTLE) != '0) begin
							res.refusal_alert = ALERT_THROTTLE;
						end else begin
							res.refusal_alert = ALERT_NONE;
						end
					end
				end else if (!hits_n[WIN_ARM]) begin
					armed_n = 1'b0;
					res.disarm_cause = CAUSE_SWITCH;
				end
				priority if (hits_n[WIN_WAYPOINT]) begin
					mode_n = MODE_WAYPOINT;
				end else if (hits_n[WIN_GPS]) begin
					mode_n = MODE_GPS;
				end else if (hits_n[WIN_ALTHOLD]) begin
					mode_n = MODE_ALTHOLD;
				end else if (hits_n[WIN_ANGLE]) begin
					mode_n = MODE_ANGLE;
				end else begin
					mode_n = MODE_ACRO;
				end
				res.mode_changed = mode_n != mode_q;
			end
		end
		res.armed = armed_n;
		res.block_flags = flags_n;
		res.flight_mode = mode_n;
		res.power_enable = hits_n[WIN_POWER] || !win_q[WIN_POWER].enable;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			hold_q <= '0;
			flags_q <= '0;
			mode_q <= MODE_ACRO;
			slot_q <= '0;
			pend_q <= '0;
			hits_q <= '0;
			thr_q <= 1'b0;
		end else if (s1_go) begin
			armed_q <= armed_n;
			hold_q <= hold_n;
			flags_q <= flags_n;
			mode_q <= mode_n;
			slot_q <= slot_n;
			pend_q <= pend_n;
			hits_q <= hits_n;
			thr_q <= thr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_go && s1_emits) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_emits) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	`RCAMS_ASSERT_NOW(a_stall_needs_item, item_stall, s1_valid_s1,
		"Input stalled with no item in the input register.")
	`RCAMS_ASSERT_NOW(a_arm_after_hold, $rose(armed_q), hold_q == 4'(ARM_HOLD_PACKETS),
		"Armed without the arm switch held for the required packets.")
	`RCAMS_ASSERT_NEXT(a_slot_clear, s1_go && !item_s1.req_type && item_s1.last_channel,
		slot_q == '0, "Channel position not cleared after the last channel.")
	`RCAMS_ASSERT_NOW(a_mode_matches, result_valid_q, result_q.flight_mode == mode_q,
		"Pending result shows a flight mode other than the current one.")

endmodule

@@ tb/arming_checker.sv @@
// Checker that predicts the arming and flight mode results and compares them with the block.
module arming_checker #(
	parameter int NUM_CHANNELS = 16,
	parameter int ARM_HOLD_PACKETS = 10
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input rcams_pkg::item_t item,
	input logic result_valid,
	input logic result_stall,
	input rcams_pkg::result_t result,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [rcams_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rcams_pkg::WIN_W-1:0] cfg_data,
	output int fail_count,
	output int outstanding
);
	import rcams_pkg::*;

	win_t win_q[NUM_WIN];
	logic armed_q;
	logic [3:0] hold_q;
	logic [7:0] flags_q;
	mode_t mode_q;
	logic [3:0] slot_q;
	logic [NUM_WIN-1:0] pend_q;
	logic [NUM_WIN-1:0] hits_q;
	logic thr_low_q;
	result_t expected_results[$];
	int mismatches = 0;

	function automatic result_t arming_result(logic arm_ev, cause_t cause, logic changed,
			alert_t alert);
		result_t r;
		r.armed = armed_q;
		r.block_flags = flags_q;
		r.flight_mode = mode_q;
		r.mode_changed = changed;
		r.arm_event = arm_ev;
		r.disarm_cause = cause;
		r.refusal_alert = alert;
		r.power_enable = hits_q[WIN_POWER] | ~win_q[WIN_POWER].enable;
		return r;
	endfunction

	task automatic predict_arming(input item_t it, output bit has_res, output result_t r);
		logic [7:0] f;
		logic arm_on;
		logic arm_ev;
		logic changed;
		mode_t newmode;
		cause_t cause;
		alert_t alert;
		has_res = 1'b0;
		arm_ev = 1'b0;
		cause = CAUSE_NONE;
		alert = ALERT_NONE;
		if (it.req_type) begin
			if (it.rx_silence_us >= SILENCE_LIMIT && armed_q) begin
				armed_q = 1'b0;
				cause = CAUSE_RX_LOSS;
			end
			r = arming_result(1'b0, cause, 1'b0, ALERT_NONE);
			has_res = 1'b1;
			return;
		end
		if (int'(slot_q) < NUM_CHANNELS) begin
			for (int i = 0; i < NUM_WIN; i++) begin
				if (win_q[i].channel == slot_q)
					pend_q[i] = win_q[i].enable && it.channel_value >= win_q[i].low &&
						it.channel_value <= win_q[i].high;
			end
			if (slot_q == THROTTLE_CH)
				thr_low_q = it.channel_value < THROTTLE_LIMIT;
		end
		if (!it.last_channel) begin
			if (slot_q < SLOT_MAX)
				slot_q++;
			return;
		end
		slot_q = '0;
		hits_q = pend_q;
		arm_on = hits_q[WIN_ARM];
		if (arm_on) begin
			if (hold_q < HOLD_MAX)
				hold_q++;
		end else begin
			hold_q = '0;
		end
		if (!armed_q) begin
			f = 8'h00;
			if (hold_q != ARM_HOLD_PACKETS) f |= FLAG_HOLD;
			if (!thr_low_q) f |= FLAG_THROTTLE;
			if (it.other_blockers[1]) f |= FLAG_NO_GPS;
			if (it.other_blockers[2]) f |= FLAG_CFG_A;
			if (!it.link_up) f |= FLAG_LINK;
			if (mode_q > MODE_ANGLE) f |= FLAG_MODE;
			if (it.other_blockers[0]) f |= FLAG_GYRO;
			if (it.other_blockers[3]) f |= FLAG_CFG_B;
			flags_q = f;
			if (f == 8'h00) begin
				armed_q = 1'b1;
				arm_ev = 1'b1;
			end else if (hold_q == ARM_HOLD_PACKETS && it.link_up) begin
				if ((f & FLAG_GYRO) != 0) alert = ALERT_GYRO;
				else if ((f & FLAG_NO_GPS) != 0) alert = ALERT_GPS;
				else if ((f & (FLAG_CFG_A | FLAG_CFG_B)) != 0) alert = ALERT_CONFIG;
				else if ((f & FLAG_LINK) != 0) alert = ALERT_LINK;
				else if ((f & FLAG_MODE) != 0) alert = ALERT_MODE;
				else if ((f & FLAG_THROTTLE) != 0) alert = ALERT_THROTTLE;
			end
		end else if (!arm_on) begin
			armed_q = 1'b0;
			cause = CAUSE_SWITCH;
		end
		if (hits_q[WIN_WAYPOINT]) newmode = MODE_WAYPOINT;
		else if (hits_q[WIN_GPS]) newmode = MODE_GPS;
		else if (hits_q[WIN_ALTHOLD]) newmode = MODE_ALTHOLD;
		else if (hits_q[WIN_ANGLE]) newmode = MODE_ANGLE;
		else newmode = MODE_ACRO;
		changed = newmode != mode_q;
		mode_q = newmode;
		r = arming_result(arm_ev, cause, changed, alert);
		has_res = 1'b1;
	endtask

	task automatic log_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] a);
		if (e !== a)
			log_failure($sformatf("%s expected %0h got %0h", name, e, a));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t exp_r;
		result_t new_r;
		bit has;
		if (!arst_n) begin
			for (int i = 0; i < NUM_WIN; i++)
				win_q[i] = WIN_RESET;
			armed_q = 1'b0;
			hold_q = '0;
			flags_q = '0;
			mode_q = MODE_ACRO;
			slot_q = '0;
			pend_q = '0;
			hits_q = '0;
			thr_low_q = 1'b0;
			expected_results.delete();
			outstanding = 0;
			fail_count = mismatches;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					log_failure($sformatf("result %0h arrived with no item waiting", result));
				end else begin
					exp_r = expected_results.pop_front();
					check_field("armed", exp_r.armed, result.armed);
					check_field("block_flags", exp_r.block_flags, result.block_flags);
					check_field("flight_mode", exp_r.flight_mode, result.flight_mode);
					check_field("mode_changed", exp_r.mode_changed, result.mode_changed);
					check_field("arm_event", exp_r.arm_event, result.arm_event);
					check_field("disarm_cause", exp_r.disarm_cause, result.disarm_cause);
					check_field("refusal_alert", exp_r.refusal_alert, result.refusal_alert);
					check_field("power_enable", exp_r.power_enable, result.power_enable);
				end
			end
			if (cfg_valid && cfg_ready && cfg_index < NUM_WIN)
				win_q[cfg_index] = cfg_data;
			if (item_valid && !item_stall) begin
				predict_arming(item, has, new_r);
				if (has)
					expected_results.push_back(new_r);
			end
			outstanding = expected_results.size();
			fail_count = mismatches;
		end
	end

endmodule

@@ tb/tb_top.sv @@
// Top of the arming and flight mode select testbench: clock, reset, stimulus and verdict.
module tb_top;
	import rcams_pkg::*;

	localparam int NUM_CH = 16;
	localparam int HOLD_PACKETS = 10;
	localparam logic REQ_CHANNEL = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE,
		STALL_PERIODIC
	} stall_style_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WIN_W-1:0] cfg_data;
	int fail_count;
	int outstanding;

	win_t win_cur[NUM_WIN];
	int items_sent;
	int burst_left;
	int holdoff_asks;
	bit steady;
	int streak_left;
	int off_left;

	rc_arming_and_mode_select #(
		.NUM_CHANNELS(NUM_CH),
		.ARM_HOLD_PACKETS(HOLD_PACKETS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	arming_checker #(
		.NUM_CHANNELS(NUM_CH),
		.ARM_HOLD_PACKETS(HOLD_PACKETS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always begin
		clk = 0;
		#5;
		clk = 1;
		#5;
	end

	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

	// The receiver changes its stall style now and then and holds off for a long stretch
	// whenever the stimulus asks for it.
	initial begin : receiver
		int done;
		int left;
		stall_style_t style;
		result_stall = 0;
		done = 0;
		left = 0;
		style = STALL_NONE;
		forever begin
			@(negedge clk);
			if (holdoff_asks > done) begin
				done++;
				result_stall = 1;
				repeat (300) @(negedge clk);
			end
			if (left == 0) begin
				style = stall_style_t'($urandom_range(0, 4));
				left = $urandom_range(20, 120);
			end
			left--;
			case (style)
				STALL_NONE: result_stall = 0;
				STALL_LIGHT: result_stall = ($urandom_range(0, 3) == 0);
				STALL_HEAVY: result_stall = ($urandom_range(0, 3) != 0);
				STALL_TOGGLE: result_stall = !result_stall;
				default: result_stall = (left % 8) < 5;
			endcase
		end
	end

	function automatic logic [10:0] value_inside(win_t w);
		int lo;
		int hi;
		lo = w.low;
		hi = (w.high > 2047) ? 2047 : w.high;
		if (lo > hi)
			return 11'($urandom);
		return 11'($urandom_range(hi, lo));
	endfunction

	function automatic logic [10:0] value_outside(win_t w);
		int lo;
		int hi;
		lo = w.low;
		hi = w.high;
		if (lo > 0 && (hi >= 2047 || $urandom_range(0, 1) == 1))
			return 11'($urandom_range((lo > 2047) ? 2047 : lo - 1, 0));
		if (hi < 2047)
			return 11'($urandom_range(2047, hi + 1));
		return 11'($urandom);
	endfunction

	function automatic logic [23:0] random_silence();
		case ($urandom_range(0, 5))
			0: return SILENCE_LIMIT;
			1: return 24'(SILENCE_LIMIT - 1);
			2: return 24'($urandom_range(24'hFFFFFF, SILENCE_LIMIT));
			default: return 24'($urandom_range(SILENCE_LIMIT - 1, 0));
		endcase
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid = 0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		item = it;
		item_valid = 1;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_tick(input logic [23:0] silence);
		item_t it;
		it.req_type = REQ_TICK;
		it.channel_value = 11'($urandom);
		it.last_channel = 1'($urandom);
		it.link_up = 1'($urandom);
		it.rx_silence_us = silence;
		it.other_blockers = 4'($urandom);
		send_item(it);
	endtask

	task automatic send_channel(input logic [10:0] v, input logic last, input logic link,
			input logic [3:0] other);
		item_t it;
		it.req_type = REQ_CHANNEL;
		it.channel_value = v;
		it.last_channel = last;
		it.link_up = link;
		it.rx_silence_us = 24'($urandom);
		it.other_blockers = other;
		send_item(it);
	endtask

	// Channel values are chosen so that a configured window on that position is hit or
	// missed as asked; the arm window decides last where windows share a channel.
	task automatic send_packet(input int n_ch, input logic [NUM_WIN-1:0] want,
			input logic thr_low, input logic link, input logic [3:0] other);
		logic [10:0] v;
		logic last;
		for (int p = 0; p < n_ch; p++) begin
			v = 11'($urandom);
			if (p == THROTTLE_CH)
				v = thr_low ? 11'($urandom_range(1019, 0)) : 11'($urandom_range(2047, 1020));
			for (int i = NUM_WIN - 1; i >= 0; i--) begin
				if (win_cur[i].enable && win_cur[i].channel == p)
					v = want[i] ? value_inside(win_cur[i]) : value_outside(win_cur[i]);
			end
			if ($urandom_range(0, 15) == 0)
				send_tick(random_silence());
			last = (p == n_ch - 1);
			send_channel(v, last, last ? link : 1'($urandom),
				last ? other : 4'($urandom));
		end
	endtask

	task automatic program_windows();
		for (int i = 0; i < NUM_WIN; i++) begin
			cfg_valid = 1;
			cfg_index = CFG_IDX_W'(i);
			cfg_data = win_cur[i];
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid = 0;
	endtask

	task automatic wait_idle();
		item_valid = 0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_windows(input bit extreme);
		int ch;
		for (int i = 0; i < NUM_WIN; i++) begin
			win_cur[i].enable = ($urandom_range(0, 4) != 0);
			win_cur[i].channel = 4'($urandom_range(0, 4));
			win_cur[i].low = 12'($urandom_range(1900, 900));
			win_cur[i].high = 12'($urandom_range(2047, win_cur[i].low));
			if ($urandom_range(0, 7) == 0)
				win_cur[i].high = 12'($urandom);
		end
		ch = $urandom_range(0, 3);
		win_cur[WIN_ARM].enable = 1;
		win_cur[WIN_ARM].channel = 4'((ch == THROTTLE_CH) ? 4 : ch);
		win_cur[WIN_ARM].low = 12'($urandom_range(1800, 1500));
		win_cur[WIN_ARM].high = $urandom_range(0, 1) ? 12'd2047 : 12'd4095;
		if (extreme) begin
			win_cur[WIN_ARM] = '{enable: 1'b1, channel: 4'd0, high: 12'd4095, low: 12'd0};
			win_cur[WIN_ANGLE] = win_t'(29'h1FFFFFFF);
			win_cur[WIN_ALTHOLD] = win_t'(29'h0);
			win_cur[WIN_GPS] = '{enable: 1'b1, channel: 4'd1, high: 12'd100, low: 12'd2000};
			win_cur[WIN_WAYPOINT] = '{enable: 1'b1, channel: 4'd15, high: 12'd0, low: 12'd0};
			win_cur[WIN_POWER].enable = 0;
		end
	endtask

	task automatic random_traffic(input int quota);
		int stop_at;
		int pick;
		int max_ch;
		int n_ch;
		int r;
		logic [NUM_WIN-1:0] want;
		logic [63:0] raw;
		stop_at = items_sent + quota;
		max_ch = 3;
		for (int i = 0; i < NUM_WIN; i++) begin
			if (win_cur[i].enable && win_cur[i].channel < 8 && win_cur[i].channel + 1 > max_ch)
				max_ch = win_cur[i].channel + 1;
		end
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				send_tick(random_silence());
			end else if (pick < 17) begin
				raw = {$urandom, $urandom};
				send_item(raw[$bits(item_t)-1:0]);
			end else begin
				if (streak_left == 0 && off_left == 0) begin
					streak_left = $urandom_range(13, 8);
					off_left = $urandom_range(4, 1);
				end
				for (int i = 0; i < NUM_WIN; i++)
					want[i] = ($urandom_range(0, 9) == 0);
				want[WIN_ARM] = (streak_left > 0);
				want[WIN_POWER] = 1'($urandom);
				if (streak_left > 0)
					streak_left--;
				else
					off_left--;
				r = $urandom_range(0, 19);
				if (r == 0)
					n_ch = $urandom_range(2, 1);
				else if (r == 1)
					n_ch = $urandom_range(20, 17);
				else
					n_ch = $urandom_range(max_ch + 2, max_ch);
				send_packet(n_ch, want, $urandom_range(0, 9) != 0, $urandom_range(0, 19) != 0,
					($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'h0);
			end
		end
	endtask

	initial begin
		arst_n = 0;
		item_valid = 0;
		item = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		items_sent = 0;
		burst_left = 0;
		holdoff_asks = 0;
		steady = 0;
		streak_left = 0;
		off_left = 0;
		for (int i = 0; i < NUM_WIN; i++)
			win_cur[i] = WIN_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Default windows: nothing configured, so power stays enabled and no window hits.
		send_tick(24'd0);
		send_channel(11'd0, 1'b0, 1'b1, 4'h0);
		send_channel(11'h7FF, 1'b0, 1'b0, 4'hF);
		send_channel(11'h2AA, 1'b1, 1'b0, 4'hF);
		send_tick(24'hFFFFFF);
		wait_idle();

		win_cur[WIN_ARM] = '{enable: 1'b1, channel: 4'd0, high: 12'd2047, low: 12'd1700};
		win_cur[WIN_ANGLE] = '{enable: 1'b1, channel: 4'd1, high: 12'd1599, low: 12'd1300};
		win_cur[WIN_ALTHOLD] = '{enable: 1'b1, channel: 4'd1, high: 12'd1799, low: 12'd1600};
		win_cur[WIN_GPS] = '{enable: 1'b1, channel: 4'd1, high: 12'd1949, low: 12'd1800};
		win_cur[WIN_WAYPOINT] = '{enable: 1'b1, channel: 4'd1, high: 12'd2047, low: 12'd1950};
		win_cur[WIN_POWER] = '{enable: 1'b1, channel: 4'd0, high: 12'd1800, low: 12'd1500};
		program_windows();

		// One full packet sets throttle low and angle mode; the one-channel packets that
		// follow keep those decisions and complete the arm hold.
		send_channel(11'd1800, 1'b0, 1'b1, 4'h0);
		send_channel(11'd1400, 1'b0, 1'b1, 4'h0);
		send_channel(11'd900, 1'b1, 1'b1, 4'h0);
		repeat (HOLD_PACKETS - 1)
			send_channel(11'd1800, 1'b1, 1'b1, 4'h0);
		send_channel(11'd1900, 1'b0, 1'b1, 4'h0);
		send_tick(24'(SILENCE_LIMIT - 1));
		send_tick(SILENCE_LIMIT);
		send_channel(11'd2047, 1'b0, 1'b1, 4'h0);
		send_channel(11'd1019, 1'b1, 1'b1, 4'h0);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			random_windows(ph == 2);
			program_windows();
			if (ph == 1) begin
				steady = 1;
				holdoff_asks++;
			end
			random_traffic(90);
			steady = 0;
		end

		item_valid = 0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rcams_pkg.sv
rtl/rc_arming_and_mode_select.sv
tb/arming_checker.sv
tb/tb_top.sv
